// File: src/rbh_pkg.sv
// Package for the range binning block with hysteresis.
// Holds field widths, register codes and the configuration struct.
// No dependencies.
package rbh_pkg;

  localparam int unsigned ChanW       = 8;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned BinW        = 3;
  localparam int unsigned CntW        = 4;
  localparam int unsigned NumBinSlots = 8;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 64;

  localparam int unsigned ChannelsDefault = 8;
  localparam int unsigned MaxBinsDefault  = 8;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    RegLowerLo  = 3'd0,
    RegLowerHi  = 3'd1,
    RegUpperLo  = 3'd2,
    RegUpperHi  = 3'd3,
    RegBinCount = 3'd4,
    RegClamp    = 3'd5,
    RegHystEn   = 3'd6,
    RegHystW    = 3'd7
  } cfg_reg_e;

  // Live configuration as seen by the datapath
  typedef struct packed {
    logic [NumBinSlots-1:0][SampleW-1:0] lower;
    logic [NumBinSlots-1:0][SampleW-1:0] upper;
    logic [CntW-1:0]                     bin_count;
    logic                                clamp;
    logic                                hyst_en;
    logic [SampleW-1:0]                  hyst_width;
  } cfg_t;

  // Classifier result handed to the hysteresis stage
  typedef struct packed {
    logic [BinW-1:0] bin;
    logic            invalid;
    logic [CntW-1:0] eff_cnt;
  } cls_t;

endpackage

// File: src/rbh_if.sv
// Stream interfaces of the range binning block: sample in, bin out.
// Depends on rbh_pkg for field widths.
interface rbh_in_if
  import rbh_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ChanW-1:0]   channel;
  logic [SampleW-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface rbh_out_if
  import rbh_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [BinW-1:0] bin_index;
  logic            invalid;

  modport source (output valid, output bin_index, output invalid, input ready);
  modport sink   (input valid, input bin_index, input invalid, output ready);
endinterface

// File: src/range_binning_hysteresis_top.sv
// Range binning with per-channel hysteresis. Takes one word per cycle unless the
// result register is full and not being read, and returns one result word per
// input word. An accepted word waits in the input register, where the parallel bin
// compares and the hysteresis check run, and is then offered from the result
// register. The per-channel last-bin store is read when a word is accepted and
// written when it completes, and it forwards a same-channel update to the
// following word. Any configuration write clears the store; write registers only
// while no word is in flight.
module range_binning_hysteresis_top
  import rbh_pkg::*;
#(
  parameter int unsigned Channels = ChannelsDefault,
  parameter int unsigned MaxBins  = MaxBinsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  rbh_in_if.sink              in_i,
  rbh_out_if.source           out_o
);

  localparam int unsigned IdxW = (Channels > 1) ? $clog2(Channels) : 1;
  localparam logic [ChanW:0] ChanLimit = (ChanW + 1)'(Channels);

  cfg_t cfg;
  cls_t cls;
  logic clr;

  logic               s1_vld_q;
  logic [ChanW-1:0]   s1_ch_q;
  logic [SampleW-1:0] s1_smp_q;
  logic               out_vld_q;
  logic [BinW-1:0]    out_bin_q;
  logic               out_inv_q;

  logic            acc, adv, ch_ok;
  logic [BinW-1:0] res_bin;
  logic            res_inv;

  // handshake: input register moves on when the result register frees up
  assign adv          = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready   = !s1_vld_q || adv;
  assign acc          = in_i.valid && in_i.ready;
  assign ch_ok        = {1'b0, s1_ch_q} < ChanLimit;

  rbh_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .clr_o       (clr)
  );

  rbh_classify #(.MaxBins(MaxBins)) u_cls (
    .cfg_i    (cfg),
    .sample_i (s1_smp_q),
    .cls_o    (cls)
  );

  rbh_hyst_store #(.Channels(Channels), .IdxW(IdxW)) u_hyst (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (clr),
    .acc_i     (acc),
    .acc_idx_i (in_i.channel[IdxW-1:0]),
    .adv_i     (adv),
    .ch_ok_i   (ch_ok),
    .idx_i     (s1_ch_q[IdxW-1:0]),
    .sample_i  (s1_smp_q),
    .cfg_i     (cfg),
    .cls_i     (cls),
    .bin_o     (res_bin),
    .invalid_o (res_inv)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_ch_q  <= in_i.channel;
      s1_smp_q <= in_i.sample;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_o.ready) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_bin_q <= res_inv ? '0 : res_bin;
      out_inv_q <= res_inv;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.bin_index = out_bin_q;
  assign out_o.invalid   = out_inv_q;

  // a stalled input word stays put
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !adv |=> s1_vld_q && $stable(s1_ch_q) && $stable(s1_smp_q))
    else $error("input register lost or changed a stalled word");

  // a completed word shows up as a result
  a_adv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("completed word did not reach the result register");

  // an invalid result carries bin zero
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_inv_q |-> out_bin_q == '0)
    else $error("invalid result with nonzero bin");

  // an empty result register never blocks input
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_i.ready)
    else $error("input stalled while result register is empty");

endmodule

// File: src/rbh_cfg_regs.sv
// Configuration register file of the range binning block.
// Depends on rbh_pkg; emits a store clear on every write.
module rbh_cfg_regs
  import rbh_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o,
  output logic                clr_o
);

  logic [CfgDataW-1:0] lower_lo_q, lower_hi_q, upper_lo_q, upper_hi_q;
  logic [CntW-1:0]     bin_count_q;
  logic                clamp_q, hyst_en_q;
  logic [SampleW-1:0]  hyst_w_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_lo_q  <= '0;
      lower_hi_q  <= '0;
      upper_lo_q  <= '0;
      upper_hi_q  <= '0;
      bin_count_q <= '0;
      clamp_q     <= 1'b0;
      hyst_en_q   <= 1'b0;
      hyst_w_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegLowerLo:  lower_lo_q  <= cfg_wdata_i;
        RegLowerHi:  lower_hi_q  <= cfg_wdata_i;
        RegUpperLo:  upper_lo_q  <= cfg_wdata_i;
        RegUpperHi:  upper_hi_q  <= cfg_wdata_i;
        RegBinCount: bin_count_q <= cfg_wdata_i[CntW-1:0];
        RegClamp:    clamp_q     <= cfg_wdata_i[0];
        RegHystEn:   hyst_en_q   <= cfg_wdata_i[0];
        RegHystW:    hyst_w_q    <= cfg_wdata_i[SampleW-1:0];
        default:     hyst_w_q    <= hyst_w_q;
      endcase
    end
  end

  // every index is a listed register, so every write clears the store
  assign clr_o = cfg_we_i;

  assign cfg_o.lower      = {lower_hi_q, lower_lo_q};
  assign cfg_o.upper      = {upper_hi_q, upper_lo_q};
  assign cfg_o.bin_count  = bin_count_q;
  assign cfg_o.clamp      = clamp_q;
  assign cfg_o.hyst_en    = hyst_en_q;
  assign cfg_o.hyst_width = hyst_w_q;

endmodule

// File: src/rbh_classify.sv
// Parallel bin compare and first-match select for one sample.
// Depends on rbh_pkg; purely combinational.
module rbh_classify
  import rbh_pkg::*;
#(
  parameter int unsigned MaxBins = MaxBinsDefault
) (
  input  cfg_t               cfg_i,
  input  logic [SampleW-1:0] sample_i,
  output cls_t               cls_o
);

  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxBins);

  logic [CntW-1:0]    eff_cnt;
  logic [MaxBins-1:0] hit;
  logic               any_hit;
  logic [BinW-1:0]    first_bin;
  logic [BinW-1:0]    last_bin;
  logic               below_first;

  // bin count saturates at the bin limit
  assign eff_cnt = (cfg_i.bin_count > MaxCnt) ? MaxCnt : cfg_i.bin_count;

  // one range compare per bin, all in parallel
  always_comb begin
    for (int unsigned i = 0; i < MaxBins; i++) begin
      hit[i] = (CntW'(i) < eff_cnt) &&
               ($signed(sample_i) >= $signed(cfg_i.lower[i])) &&
               ($signed(sample_i) <  $signed(cfg_i.upper[i]));
    end
  end

  // lowest matching bin wins
  always_comb begin
    first_bin = '0;
    for (int i = MaxBins - 1; i >= 0; i--) begin
      if (hit[i]) first_bin = BinW'(i);
    end
  end

  assign any_hit     = |hit;
  assign last_bin    = BinW'(eff_cnt - CntW'(1));
  assign below_first = $signed(sample_i) < $signed(cfg_i.lower[0]);

  // no bins, a match, the clamp fallback, or an invalid result
  always_comb begin
    cls_o.eff_cnt = eff_cnt;
    priority if (eff_cnt == '0) begin
      cls_o.bin     = '0;
      cls_o.invalid = !cfg_i.clamp;
    end else if (any_hit) begin
      cls_o.bin     = first_bin;
      cls_o.invalid = 1'b0;
    end else if (cfg_i.clamp) begin
      cls_o.bin     = below_first ? '0 : last_bin;
      cls_o.invalid = 1'b0;
    end else begin
      cls_o.bin     = '0;
      cls_o.invalid = 1'b1;
    end
  end

endmodule

// File: src/rbh_hyst_store.sv
// Per-channel last-bin store and the hysteresis hold decision.
// Depends on rbh_pkg; bin memory is read at accept time with write forwarding.
module rbh_hyst_store
  import rbh_pkg::*;
#(
  parameter int unsigned Channels = ChannelsDefault,
  parameter int unsigned IdxW     = (Channels > 1) ? $clog2(Channels) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_i,       // config write: forget all channels
  input  logic               acc_i,       // word enters the input register
  input  logic [IdxW-1:0]    acc_idx_i,   // its channel
  input  logic               adv_i,       // word in the input register completes
  input  logic               ch_ok_i,
  input  logic [IdxW-1:0]    idx_i,
  input  logic [SampleW-1:0] sample_i,
  input  cfg_t               cfg_i,
  input  cls_t               cls_i,
  output logic [BinW-1:0]    bin_o,
  output logic               invalid_o
);

  logic [BinW-1:0]     bin_mem [Channels];
  logic [Channels-1:0] vld_q;
  logic [BinW-1:0]     last_q;

  logic            use_store, wr_en;
  logic            adjacent, near_edge, in_window, hold;
  logic [BinW-1:0] lo_bin;
  logic [CntW-1:0] cur4, last4;
  logic signed [SampleW-1:0] ub;
  logic signed [SampleW+2:0] smp2, win_lo, win_hi;

  // decision on the word in the input register
  assign use_store = ch_ok_i && cfg_i.hyst_en && !cls_i.invalid;
  assign cur4      = {1'b0, cls_i.bin};
  assign last4     = {1'b0, last_q};
  assign adjacent  = (cur4 == last4 + CntW'(1)) || (cur4 + CntW'(1) == last4);
  assign lo_bin    = (cls_i.bin < last_q) ? cls_i.bin : last_q;
  assign near_edge = ({1'b0, lo_bin} + CntW'(1)) < cls_i.eff_cnt;
  assign ub        = $signed(cfg_i.upper[lo_bin]);

  // window in doubled units keeps the half width exact
  assign smp2   = $signed({{2{sample_i[SampleW-1]}}, sample_i, 1'b0});
  assign win_lo = $signed({{2{ub[SampleW-1]}}, ub, 1'b0}) -
                  $signed({3'b000, cfg_i.hyst_width});
  assign win_hi = $signed({{2{ub[SampleW-1]}}, ub, 1'b0}) +
                  $signed({3'b000, cfg_i.hyst_width});
  assign in_window = (smp2 >= win_lo) && (smp2 <= win_hi);

  assign hold = use_store && vld_q[idx_i] && (last_q != cls_i.bin) && adjacent &&
                (cfg_i.hyst_width != '0) && near_edge && in_window;

  // store is written when hysteresis is on and a valid result is not held
  assign wr_en = adv_i && use_store && !hold;

  assign bin_o     = hold ? last_q : cls_i.bin;
  assign invalid_o = !ch_ok_i || cls_i.invalid;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[idx_i] <= 1'b1;
    end
  end

  // bin memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bin_mem[idx_i] <= bin_o;
    end
  end

  // registered read, forwarding a write to the same channel in this cycle
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      last_q <= (wr_en && (idx_i == acc_idx_i)) ? bin_o : bin_mem[acc_idx_i];
    end
  end

endmodule
